### src/shp_pkg.sv
// ----------------------------------------------------------------------------
// SCGI header parser package
// Shared types, character constants and the key table used by the parser
// core and its key/value pair unit.
// ----------------------------------------------------------------------------
package shp_pkg;

    // Default widths of the internal length and content value registers.
    localparam int LENGTH_BITS_DEF  = 20;
    localparam int CONTENT_BITS_DEF = 32;

    // Fixed widths of the register and result fields.
    localparam int MAX_LEN_W  = 20;
    localparam int HDR_LEN_W  = 20;
    localparam int CONTENT_W  = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_MAX_HEADER_LENGTH = 1'b0;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = '1;

    // Characters that the parser recognises.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Length of the key that is searched for, and the saturated index limit.
    localparam logic [3:0] KEY_LEN     = 4'd14;
    localparam logic [3:0] KEY_IDX_MAX = 4'd15;

    typedef enum logic [2:0] {
        PH_LEN   = 3'd0,
        PH_HDR   = 3'd1,
        PH_COMMA = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERR   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_PARSING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ROLE_LEN_DIGIT = 3'd0,
        ROLE_COLON     = 3'd1,
        ROLE_KEY       = 3'd2,
        ROLE_VALUE     = 3'd3,
        ROLE_NUL       = 3'd4,
        ROLE_COMMA     = 3'd5,
        ROLE_IGNORED   = 3'd6
    } t_role;

    // Control from the core to the pair unit for one byte.
    typedef struct packed {
        logic step;        // the byte moves into the result register
        logic clear_all;   // first byte of a request: drop all pair state
        logic hdr_byte;    // the byte lies inside the header body
        logic clear_pair;  // drop the pair in progress after this byte
    } t_pair_ctl;

    // Upper-case text of the searched key, one character per index.
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h4F; // O
            4'd2:    ch = 8'h4E; // N
            4'd3:    ch = 8'h54; // T
            4'd4:    ch = 8'h45; // E
            4'd5:    ch = 8'h4E; // N
            4'd6:    ch = 8'h54; // T
            4'd7:    ch = 8'h5F; // _
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h45; // E
            4'd10:   ch = 8'h4E; // N
            4'd11:   ch = 8'h47; // G
            4'd12:   ch = 8'h54; // T
            4'd13:   ch = 8'h48; // H
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

### src/shp_pair_unit.sv
// ----------------------------------------------------------------------------
// SCGI header parser key/value pair unit
// Tracks the key and value strings of the header body, matches keys against
// CONTENT_LENGTH and captures the saturated decimal value of a match.
// ----------------------------------------------------------------------------
module shp_pair_unit #(
    parameter int CONTENT_BITS = shp_pkg::CONTENT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  shp_pkg::t_pair_ctl      i_ctl,
    input  logic [7:0]              i_byte,
    output shp_pkg::t_role          o_role,
    output logic [CONTENT_BITS-1:0] o_found_length,
    output logic                    o_found_flag
);
    import shp_pkg::*;

    localparam int ACC_BITS = CONTENT_BITS + 4;

    logic                    r_in_value,   n_in_value,   c_in_value;
    logic [3:0]              r_key_idx,    n_key_idx,    c_key_idx;
    logic                    r_mismatch,   n_mismatch,   c_mismatch;
    logic                    r_at_start,   n_at_start,   c_at_start;
    logic                    r_in_digits,  n_in_digits,  c_in_digits;
    logic [CONTENT_BITS-1:0] r_acc,        n_acc,        c_acc;
    logic [CONTENT_BITS-1:0] r_found,      n_found,      c_found;
    logic                    r_found_flag, n_found_flag, c_found_flag;

    logic                    is_digit;
    logic [3:0]              digit;
    logic [7:0]              upper;
    logic [ACC_BITS-1:0]     acc_ext;
    logic [ACC_BITS-1:0]     acc_prod;
    logic [CONTENT_BITS-1:0] acc_sat;

    // A new request starts from the reset values.
    assign c_in_value   = i_ctl.clear_all ? 1'b0 : r_in_value;
    assign c_key_idx    = i_ctl.clear_all ? 4'd0 : r_key_idx;
    assign c_mismatch   = i_ctl.clear_all ? 1'b0 : r_mismatch;
    assign c_at_start   = i_ctl.clear_all ? 1'b1 : r_at_start;
    assign c_in_digits  = i_ctl.clear_all ? 1'b0 : r_in_digits;
    assign c_acc        = i_ctl.clear_all ? '0   : r_acc;
    assign c_found      = i_ctl.clear_all ? '0   : r_found;
    assign c_found_flag = i_ctl.clear_all ? 1'b0 : r_found_flag;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = i_byte[3:0];
    assign upper    = ((i_byte >= CH_LC_A) && (i_byte <= CH_LC_Z)) ? i_byte - CASE_OFS
                                                                   : i_byte;

    // Times ten by shift and add; any bit above the value width means saturation.
    assign acc_ext  = ACC_BITS'(c_acc);
    assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + ACC_BITS'(digit);
    assign acc_sat  = (|acc_prod[ACC_BITS-1:CONTENT_BITS]) ? '1
                                                           : acc_prod[CONTENT_BITS-1:0];

    always_comb begin
        n_in_value   = c_in_value;
        n_key_idx    = c_key_idx;
        n_mismatch   = c_mismatch;
        n_at_start   = c_at_start;
        n_in_digits  = c_in_digits;
        n_acc        = c_acc;
        n_found      = c_found;
        n_found_flag = c_found_flag;
        o_role       = ROLE_IGNORED;

        if (i_ctl.hdr_byte) begin
            if (!c_in_value) begin
                if (i_byte == CH_NUL) begin
                    o_role      = ROLE_NUL;
                    n_in_value  = 1'b1;
                    n_at_start  = 1'b1;
                    n_in_digits = 1'b0;
                    n_acc       = '0;
                end else begin
                    o_role = ROLE_KEY;
                    if ((c_key_idx >= KEY_LEN) || (key_char(c_key_idx) != upper)) begin
                        n_mismatch = 1'b1;
                    end
                    if (c_key_idx < KEY_IDX_MAX) begin
                        n_key_idx = c_key_idx + 4'd1;
                    end
                end
            end else begin
                if (i_byte == CH_NUL) begin
                    o_role = ROLE_NUL;
                    if (!c_mismatch && (c_key_idx == KEY_LEN)) begin
                        n_found      = c_acc;
                        n_found_flag = 1'b1;
                    end
                    n_in_value  = 1'b0;
                    n_key_idx   = 4'd0;
                    n_mismatch  = 1'b0;
                    n_at_start  = 1'b1;
                    n_in_digits = 1'b0;
                    n_acc       = '0;
                end else begin
                    o_role = ROLE_VALUE;
                    if (c_at_start) begin
                        n_at_start = 1'b0;
                        if (is_digit) begin
                            n_in_digits = 1'b1;
                            n_acc       = CONTENT_BITS'(digit);
                        end
                    end else if (c_in_digits) begin
                        if (!is_digit) begin
                            n_in_digits = 1'b0;
                        end else begin
                            n_acc = acc_sat;
                        end
                    end
                end
            end
        end

        // The pair in progress is dropped; a captured value survives.
        if (i_ctl.clear_pair) begin
            n_in_value  = 1'b0;
            n_key_idx   = 4'd0;
            n_mismatch  = 1'b0;
            n_at_start  = 1'b1;
            n_in_digits = 1'b0;
            n_acc       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value   <= 1'b0;
            r_key_idx    <= 4'd0;
            r_mismatch   <= 1'b0;
            r_at_start   <= 1'b1;
            r_in_digits  <= 1'b0;
            r_acc        <= '0;
            r_found      <= '0;
            r_found_flag <= 1'b0;
        end else if (i_ctl.step) begin
            r_in_value   <= n_in_value;
            r_key_idx    <= n_key_idx;
            r_mismatch   <= n_mismatch;
            r_at_start   <= n_at_start;
            r_in_digits  <= n_in_digits;
            r_acc        <= n_acc;
            r_found      <= n_found;
            r_found_flag <= n_found_flag;
        end
    end

    assign o_found_length = n_found;
    assign o_found_flag   = n_found_flag;

endmodule

### src/scgi_header_parser_core.sv
// ----------------------------------------------------------------------------
// SCGI header parser core
// Parses an SCGI netstring request header one byte per transaction and
// reports the byte's role, the parse status and any CONTENT_LENGTH value.
// ----------------------------------------------------------------------------
// A taken input transaction is held in the input register; its result is
// then loaded into the result register, which drives the outputs.
// Throughput: one byte per cycle unless the result side stalls; the parse
// state for the next byte is written together with the current byte's result.
// Reset (synchronous, active low) empties both registers, returns the parser
// to the length digits phase and sets max_header_length to its largest value.
// ----------------------------------------------------------------------------
module scgi_header_parser_core #(
    parameter int LENGTH_BITS  = shp_pkg::LENGTH_BITS_DEF,
    parameter int CONTENT_BITS = shp_pkg::CONTENT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Input byte channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_first_byte,

    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_parse_status,
    output logic [2:0]                     o_byte_role,
    output logic [shp_pkg::CONTENT_W-1:0]  o_body_len,
    output logic                           o_body_len_seen,
    output logic [shp_pkg::HDR_LEN_W-1:0]  o_header_length,

    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [shp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [shp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [shp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import shp_pkg::*;

    // Width in which a length digit is folded in and compared with the limit.
    localparam int LV_BITS = ((LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W) + 4;
    localparam logic [LV_BITS-1:0] LEN_MAX = {{(LV_BITS-LENGTH_BITS){1'b0}},
                                              {LENGTH_BITS{1'b1}}};

    // ------------------------------------------------------------------
    // Configuration register, read directly by the parse logic. Writes must
    // be made only while the parser is idle; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [MAX_LEN_W-1:0] r_max_len;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_MAX_HEADER_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_write) begin
            r_max_len <= pwdata[MAX_LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_HEADER_LENGTH) ? APB_DATA_W'(r_max_len) : '0;

    // ------------------------------------------------------------------
    // Handshake. The input register holds one byte; it moves on into the
    // result register whenever that register is empty or being emptied,
    // so a new transaction is taken in every cycle of an unstalled stream.
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       advance;
    logic       in_take;

    assign advance    = r_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parse state. A first byte makes the byte act on reset state.
    // ------------------------------------------------------------------
    t_phase                 r_phase,      n_phase,      c_phase;
    logic [LENGTH_BITS-1:0] r_decl,       n_decl,       c_decl;
    logic [LENGTH_BITS-1:0] r_left,       n_left,       c_left;
    logic                   r_digit_seen, n_digit_seen, c_digit_seen;

    assign c_phase      = r_in_first ? PH_LEN : r_phase;
    assign c_decl       = r_in_first ? '0     : r_decl;
    assign c_left       = r_in_first ? '0     : r_left;
    assign c_digit_seen = r_in_first ? 1'b0   : r_digit_seen;

    logic                   is_digit;
    logic [LV_BITS-1:0]     decl_ext;
    logic [LV_BITS-1:0]     len_next;
    logic [LV_BITS-1:0]     max_ext;
    logic [LV_BITS-1:0]     len_lim;
    logic                   len_over;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   hdr_end;

    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign decl_ext = LV_BITS'(c_decl);
    // Declared length times ten plus the new digit, by shift and add.
    assign len_next = (decl_ext << 3) + (decl_ext << 1) + LV_BITS'(r_in_byte[3:0]);
    assign max_ext  = LV_BITS'(r_max_len);
    // The tighter of the configured limit and the register range applies.
    assign len_lim  = (max_ext < LEN_MAX) ? max_ext : LEN_MAX;
    assign len_over = len_next > len_lim;
    assign left_dec = (c_left != '0) ? c_left - LENGTH_BITS'(1) : '0;
    assign hdr_end  = (c_phase == PH_HDR) && (left_dec == '0);

    // Next-state logic of the parse phase and the length registers.
    always_comb begin
        n_phase      = c_phase;
        n_decl       = c_decl;
        n_left       = c_left;
        n_digit_seen = c_digit_seen;
        unique case (c_phase)
            PH_LEN: begin
                if (is_digit) begin
                    if (len_over) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_decl       = len_next[LENGTH_BITS-1:0];
                        n_digit_seen = 1'b1;
                    end
                end else if (r_in_byte == CH_COLON) begin
                    if (!c_digit_seen) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_left  = c_decl;
                        n_phase = (c_decl == '0) ? PH_COMMA : PH_HDR;
                    end
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_HDR: begin
                n_left = left_dec;
                if (hdr_end) begin
                    n_phase = PH_COMMA;
                end
            end
            PH_COMMA: begin
                n_phase = (r_in_byte == CH_COMMA) ? PH_DONE : PH_ERR;
            end
            PH_DONE, PH_ERR: begin
                n_phase = c_phase;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase
    end

    // Output logic: status, role and control of the pair unit.
    t_status   res_status;
    t_role     res_role;
    t_role     pair_role;
    t_pair_ctl pair_ctl;

    always_comb begin
        res_status          = ST_PARSING;
        res_role            = ROLE_IGNORED;
        pair_ctl.step       = advance;
        pair_ctl.clear_all  = r_in_first;
        pair_ctl.hdr_byte   = 1'b0;
        pair_ctl.clear_pair = 1'b0;
        unique case (c_phase)
            PH_LEN: begin
                if (is_digit) begin
                    res_role = ROLE_LEN_DIGIT;
                    if (len_over) begin
                        res_status = ST_ERROR;
                    end
                end else if (r_in_byte == CH_COLON) begin
                    res_role = ROLE_COLON;
                    if (!c_digit_seen) begin
                        res_status = ST_ERROR;
                    end else begin
                        pair_ctl.clear_pair = 1'b1;
                    end
                end else begin
                    res_status = ST_ERROR;
                end
            end
            PH_HDR: begin
                res_role            = pair_role;
                pair_ctl.hdr_byte   = 1'b1;
                pair_ctl.clear_pair = hdr_end;
            end
            PH_COMMA: begin
                if (r_in_byte == CH_COMMA) begin
                    res_role   = ROLE_COMMA;
                    res_status = ST_COMPLETE;
                end else begin
                    res_status = ST_ERROR;
                end
            end
            PH_DONE, PH_ERR: begin
                res_status = ST_IDLE;
            end
            default: begin
                res_status = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_decl       <= '0;
            r_left       <= '0;
            r_digit_seen <= 1'b0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_decl       <= n_decl;
            r_left       <= n_left;
            r_digit_seen <= n_digit_seen;
        end
    end

    // ------------------------------------------------------------------
    // Key and value tracking inside the header body.
    // ------------------------------------------------------------------
    logic [CONTENT_BITS-1:0] found_length;
    logic                    found_flag;

    shp_pair_unit #(
        .CONTENT_BITS (CONTENT_BITS)
    ) u_pair (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (pair_ctl),
        .i_byte         (r_in_byte),
        .o_role         (pair_role),
        .o_found_length (found_length),
        .o_found_flag   (found_flag)
    );

    // The reported value saturates at the width of the result field, and the
    // reported length is the low bits of the declared length.
    logic [63:0] found_wide;
    logic [31:0] decl_wide;

    assign found_wide = 64'(found_length);
    assign decl_wide  = 32'(n_decl);

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_parse_status  <= res_status;
            o_byte_role     <= res_role;
            o_body_len      <= (|found_wide[63:CONTENT_W]) ? '1
                                                           : found_wide[CONTENT_W-1:0];
            o_body_len_seen <= found_flag;
            o_header_length <= decl_wide[HDR_LEN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The header body is only entered with bytes still to read.
    a_hdr_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR) |-> (r_left != '0))
        else $error("header phase with no bytes left");

    // A completed header always ends on the comma.
    a_complete_on_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_parse_status == ST_COMPLETE)) |-> (o_byte_role == ROLE_COMMA))
        else $error("header completion reported on a byte other than the comma");

    // A completion or an error leaves the parser in an end phase.
    a_end_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && ((res_status == ST_COMPLETE) || (res_status == ST_ERROR)))
        |=> ((r_phase == PH_DONE) || (r_phase == PH_ERR)))
        else $error("parser did not stop after completion or error");

    // The input side is only held back while a byte waits in the input register.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked byte");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// SCGI header parser core testbench
// Streams request bytes through the parser with random idle cycles on both
// channels. A byte-level parse tracker predicts the status, byte role,
// CONTENT_LENGTH value and declared header length of every result, and each
// result that leaves the core is compared in order against that prediction.
// The header length limit register is reprogrammed between phases and read
// back over the APB port.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import shp_pkg::*;

    // Clock, reset and run length.
    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int DRAIN_CYCLES  = 8;

    // Number of bytes that the random part aims for (the directed requests
    // add about two hundred more), and the length of the deliberate
    // result-side hold-off that backs the pipeline up.
    localparam int RANDOM_BYTES  = 1450;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_COUNT   = 6;

    // Largest values that the length and content registers can carry.
    localparam longint unsigned LEN_LIMIT   = (64'd1 << LENGTH_BITS_DEF) - 1;
    localparam longint unsigned CONTENT_MAX = (64'd1 << CONTENT_BITS_DEF) - 1;

    // Byte address of max_header_length on the APB port.
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_HDR_LEN = '0;

    // Key that the parser looks for, and the character that stands for a NUL
    // byte in the hand-written requests below.
    localparam string      KEY_WORD = "CONTENT_LENGTH";
    localparam logic [7:0] NUL_MARK = 8'h7C;

    // Everything that one result transaction carries, in port order.
    typedef struct packed {
        t_status                status;
        t_role                  role;
        logic [CONTENT_W-1:0]   body_len;
        logic                   len_seen;
        logic [HDR_LEN_W-1:0]   hdr_len;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Parse tracker: follows the request byte by byte, queues the verdict that
    // each accepted byte must produce and checks results against that queue.
    // ------------------------------------------------------------------------
    class parse_tracker;
        t_verdict               verdicts_due[$];
        int                     faults;
        int                     results_seen;
        logic [MAX_LEN_W-1:0]   max_len;

        t_phase                 phase;
        logic [HDR_LEN_W-1:0]   decl_len;
        logic [HDR_LEN_W-1:0]   bytes_left;
        bit                     digit_seen;
        bit                     in_value;
        logic [3:0]             key_idx;
        bit                     key_bad;
        bit                     value_fresh;
        bit                     value_digits;
        longint unsigned        value_acc;
        longint unsigned        found_len;
        bit                     found;

        function new();
            max_len = MAX_LEN_RESET;
            clear_request();
        endfunction

        function void clear_pair();
            in_value     = 1'b0;
            key_idx      = '0;
            key_bad      = 1'b0;
            value_fresh  = 1'b1;
            value_digits = 1'b0;
            value_acc    = 0;
        endfunction

        function void clear_request();
            phase      = PH_LEN;
            decl_len   = '0;
            bytes_left = '0;
            digit_seen = 1'b0;
            found_len  = 0;
            found      = 1'b0;
            clear_pair();
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // One byte inside the declared header body.
        function t_role header_byte(logic [7:0] b);
            t_role           role;
            logic [7:0]      upper;
            longint unsigned d;
            bit              digit;
            digit = (b >= CH_ZERO) && (b <= CH_NINE);
            d = 64'(b) - 64'(CH_ZERO);
            if (!in_value) begin
                if (b == CH_NUL) begin
                    role         = ROLE_NUL;
                    in_value     = 1'b1;
                    value_fresh  = 1'b1;
                    value_digits = 1'b0;
                    value_acc    = 0;
                end else begin
                    upper = (b >= CH_LC_A && b <= CH_LC_Z) ? b - CASE_OFS : b;
                    role  = ROLE_KEY;
                    if (key_idx >= KEY_LEN || KEY_WORD[key_idx] != upper) begin
                        key_bad = 1'b1;
                    end
                    if (key_idx < KEY_IDX_MAX) begin
                        key_idx++;
                    end
                end
            end else if (b == CH_NUL) begin
                role = ROLE_NUL;
                if (!key_bad && key_idx == KEY_LEN) begin
                    found_len = value_acc;
                    found     = 1'b1;
                end
                clear_pair();
            end else begin
                role = ROLE_VALUE;
                if (value_fresh) begin
                    value_fresh = 1'b0;
                    if (digit) begin
                        value_digits = 1'b1;
                        value_acc    = d;
                    end
                end else if (value_digits) begin
                    if (!digit) begin
                        value_digits = 1'b0;
                    end else if (value_acc > (CONTENT_MAX - d) / 10) begin
                        value_acc = CONTENT_MAX;
                    end else begin
                        value_acc = value_acc * 10 + d;
                    end
                end
            end
            // A pair that the end of the body cuts short is simply dropped.
            if (bytes_left > 0) begin
                bytes_left--;
            end
            if (bytes_left == 0) begin
                phase = PH_COMMA;
                clear_pair();
            end
            return role;
        endfunction

        // Notes an accepted input transaction and queues its verdict.
        function t_status take_byte(logic [7:0] b, logic first);
            t_verdict        v;
            longint unsigned lim;
            longint unsigned grown;
            v.status = ST_PARSING;
            v.role   = ROLE_IGNORED;
            if (first) begin
                clear_request();
            end
            case (phase)
                PH_LEN: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        v.role = ROLE_LEN_DIGIT;
                        lim    = (max_len < LEN_LIMIT) ? 64'(max_len) : LEN_LIMIT;
                        grown  = 64'(decl_len) * 10 + 64'(b - CH_ZERO);
                        if (grown > lim) begin
                            v.status = ST_ERROR;
                            phase    = PH_ERR;
                        end else begin
                            decl_len   = grown[HDR_LEN_W-1:0];
                            digit_seen = 1'b1;
                        end
                    end else if (b == CH_COLON) begin
                        v.role = ROLE_COLON;
                        if (!digit_seen) begin
                            v.status = ST_ERROR;
                            phase    = PH_ERR;
                        end else begin
                            bytes_left = decl_len;
                            clear_pair();
                            phase = (decl_len == 0) ? PH_COMMA : PH_HDR;
                        end
                    end else begin
                        v.status = ST_ERROR;
                        phase    = PH_ERR;
                    end
                end
                PH_HDR: begin
                    v.role = header_byte(b);
                end
                PH_COMMA: begin
                    if (b == CH_COMMA) begin
                        v.role   = ROLE_COMMA;
                        v.status = ST_COMPLETE;
                        phase    = PH_DONE;
                    end else begin
                        v.status = ST_ERROR;
                        phase    = PH_ERR;
                    end
                end
                default: begin
                    v.status = ST_IDLE;
                end
            endcase
            v.body_len = found_len[CONTENT_W-1:0];
            v.len_seen = found;
            v.hdr_len  = decl_len;
            verdicts_due.push_back(v);
            return v.status;
        endfunction

        // Checks one accepted result transaction against the oldest verdict.
        function void match_verdict(t_verdict got);
            t_verdict want;
            results_seen++;
            if (verdicts_due.size() == 0) begin
                flag($sformatf("result %0d arrived with no byte outstanding",
                               results_seen));
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want) begin
                flag($sformatf({"result %0d mismatch (expected/actual): status %0d/%0d",
                                " role %0d/%0d content %0d/%0d seen %0d/%0d",
                                " header %0d/%0d"},
                               results_seen, want.status, got.status,
                               want.role, got.role, want.body_len,
                               got.body_len, want.len_seen, got.len_seen,
                               want.hdr_len, got.hdr_len));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the core holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [7:0]             i_data_byte    = '0;
    logic                   i_first_byte   = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [1:0]             o_parse_status;
    logic [2:0]             o_byte_role;
    logic [CONTENT_W-1:0]   o_body_len;
    logic                   o_body_len_seen;
    logic [HDR_LEN_W-1:0]   o_header_length;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr          = '0;
    logic [APB_DATA_W-1:0]  pwdata         = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    parse_tracker tracker = new();

    // Idle controls shared between the stimulus and the result side. A calm
    // side inserts no idle cycles; a hold request makes the result side stall
    // for a long stretch so that the core fills up and stalls its input.
    bit tx_calm;
    bit rx_calm;
    bit hold_req;
    int stall_left;
    int busy_bytes;

    scgi_header_parser_core u_top (.*);

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Most idle stretches are short, a few are long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Appends text to a byte queue; the NUL marker becomes a real NUL byte.
    function automatic void push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) begin
            q.push_back((s[i] == NUL_MARK) ? CH_NUL : s[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random request builder. Most requests are well formed netstrings whose
    // keys and values are drawn to hit the matching logic: the real key in
    // mixed case, near misses, arbitrary keys, small, boundary and oversized
    // values, values that do not start with a digit and values with trailing
    // junk. A minority carry a wrong declared length, a damaged prefix, a
    // missing comma or are plain noise.
    // ------------------------------------------------------------------------
    function automatic void build_request(ref logic [7:0] q[$]);
        logic [7:0] body[$];
        logic [7:0] ch;
        int         cut;
        int         decl;
        q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    for (int i = 0; i < KEY_LEN; i++) begin
                        ch = KEY_WORD[i];
                        if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) begin
                            ch = ch + CASE_OFS;
                        end
                        body.push_back(ch);
                    end
                end
                3: begin
                    cut = $urandom_range(1, KEY_LEN - 1);
                    for (int i = 0; i < cut; i++) begin
                        body.push_back(KEY_WORD[i]);
                    end
                end
                4: begin
                    push_text(body, KEY_WORD);
                    if ($urandom_range(0, 1) == 1) begin
                        body[$ - $urandom_range(0, KEY_LEN - 1)] = 8'($urandom_range(1, 255));
                    end else begin
                        repeat ($urandom_range(1, 2)) body.push_back(8'($urandom_range(1, 255)));
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(1, 255)));
                end
            endcase
            body.push_back(CH_NUL);
            case ($urandom_range(0, 5))
                0: push_text(body, $sformatf("%0d", $urandom_range(0, 99999)));
                1: push_text(body, $sformatf("%0d",
                                             CONTENT_MAX + 64'($urandom_range(0, 6)) - 64'd3));
                2: begin
                    repeat ($urandom_range(11, 20)) body.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                3: begin
                    do ch = 8'($urandom_range(1, 255)); while (ch >= CH_ZERO && ch <= CH_NINE);
                    body.push_back(ch);
                    push_text(body, $sformatf("%0d", $urandom_range(0, 999)));
                end
                4: begin
                    push_text(body, $sformatf("%0d", $urandom_range(0, 999)));
                    repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(1, 255)));
                end
                default: ;
            endcase
            // Now and then the value runs into the next pair without its NUL.
            if ($urandom_range(0, 7) != 0) begin
                body.push_back(CH_NUL);
            end
        end
        decl = body.size();
        case ($urandom_range(0, 9))
            0: decl += $urandom_range(1, 3);
            1: if (decl > 0) decl -= $urandom_range(1, (decl < 3) ? decl : 3);
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) begin
            q.push_back(CH_ZERO);
        end
        push_text(q, $sformatf("%0d", decl));
        if ($urandom_range(0, 15) == 0) begin
            q.insert($urandom_range(0, q.size()), 8'($urandom));
        end
        if ($urandom_range(0, 31) == 0) begin
            q.delete();
        end
        q.push_back(CH_COLON);
        foreach (body[i]) begin
            q.push_back(body[i]);
        end
        q.push_back(($urandom_range(0, 9) != 0) ? CH_COMMA : 8'($urandom));
        repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Every task returns just after a rising edge, so that all
    // drives land as nonblocking updates at that edge. Valid stays high until
    // the transaction is taken and never looks at the stall.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic first, output t_status status);
        int gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= first;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        status = tracker.take_byte(b, first);
        // Every byte taken counts towards the length of the run.
        busy_bytes++;
    endtask

    // Sends one request. Once it has failed, only a couple of further bytes
    // are sent, since the core ignores the rest until the next first byte.
    task automatic send_request(input logic [7:0] q[$], input bit may_restart);
        t_status status;
        int      spare;
        logic    first;
        spare = -1;
        foreach (q[i]) begin
            if (spare == 0) break;
            first = (i == 0) || (may_restart && $urandom_range(0, 299) == 0);
            send_byte(q[i], first, status);
            if (spare > 0) begin
                spare--;
            end else if (status == ST_ERROR) begin
                spare = $urandom_range(0, 2);
            end
        end
    endtask

    task automatic send_text(input string s);
        logic [7:0] q[$];
        push_text(q, s);
        send_request(q, 1'b0);
    endtask

    // Drops valid and waits until every queued verdict has been matched, plus
    // a few cycles so that the pipeline is surely empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port: a setup phase and then an access phase that ends at
    // the first edge with pready high. Read data is sampled at that edge, and
    // the port then rests before the next access.
    // ------------------------------------------------------------------------
    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic max_len_readback(input logic [MAX_LEN_W-1:0] want);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b0, ADDR_MAX_HDR_LEN, '0, rdata);
        if (rdata[MAX_LEN_W-1:0] !== want) begin
            tracker.flag($sformatf("max_header_length read back %0d, expected %0d",
                                   rdata[MAX_LEN_W-1:0], want));
        end
    endtask

    task automatic program_max_len(input logic [MAX_LEN_W-1:0] value);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b1, ADDR_MAX_HDR_LEN, APB_DATA_W'(value), rdata);
        tracker.max_len = value;
        max_len_readback(value);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Each accepted result transaction is checked at the edge
    // that takes it, and the stall for the next cycle is then chosen: a long
    // hold-off when one has been requested, random stalls otherwise, or none
    // at all while the side is calm.
    // ------------------------------------------------------------------------
    initial begin : result_side
        t_verdict got;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                got = {o_parse_status, o_byte_role, o_body_len,
                       o_body_len_seen, o_header_length};
                tracker.match_verdict(got);
            end
            if (stall_left == 0) begin
                if (hold_req) begin
                    stall_left = HOLD_CYCLES;
                    hold_req   = 1'b0;
                end else if (!rx_calm) begin
                    stall_left = idle_len();
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, a check of the register's reset value, the directed
    // requests and then the random phases, each under its own length limit.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]           req[$];
        logic [MAX_LEN_W-1:0] limits[PHASE_COUNT];
        int                   calm_requests;
        t_status              status;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        max_len_readback(MAX_LEN_RESET);

        // Directed requests. The bar stands for a NUL byte.
        send_text("0:,");                            // empty header
        send_text("005:ab|c|,x");                    // leading zeros, byte after the end
        send_text("26:CONTENT_LENGTH|4294967295|,"); // largest value that fits
        send_text("27:content_Length|99999999999|,"); // mostly lower case key, saturation
        // Value not starting with a digit, then an overlong and a short key.
        send_text("53:Content_Length|x12|CONTENT_LENGTHX|5|CONTENT_LENGT|7|,");
        // Digits followed by junk, then a pair cut off by the end of the body.
        send_text("37:CONTENT_LENGTH|12ab3|CONTENT_LENGTH|9,");
        send_text("1:a;");                           // comma missing
        send_text(":");                              // colon without digits
        send_text("1a");                             // stray byte in the prefix
        send_text("1048576");                        // declared length too large
        send_text("1048575:ab");                     // largest length, abandoned
        send_byte(8'hFF, 1'b1, status);
        send_byte(8'h00, 1'b0, status);

        // The first phase keeps the reset limit; the others include the largest
        // register value, a limit of one and a few values that make long headers
        // fail part-way through the length prefix.
        limits = '{MAX_LEN_RESET, MAX_LEN_W'(1), MAX_LEN_W'($urandom_range(10, 60)),
                   MAX_LEN_W'($urandom_range(1, 1048575)), MAX_LEN_RESET,
                   MAX_LEN_W'($urandom_range(60, 400))};
        busy_bytes    = 0;
        calm_requests = 0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                drain();
                program_max_len(limits[p]);
            end
            // In one phase the result side holds off for a long stretch while
            // the input side keeps offering bytes back to back.
            if (p == 4) begin
                hold_req      = 1'b1;
                calm_requests = 4;
            end
            while (busy_bytes < RANDOM_BYTES * (p + 1) / PHASE_COUNT) begin
                build_request(req);
                tx_calm = (calm_requests > 0) || ($urandom_range(0, 4) == 0);
                rx_calm = ($urandom_range(0, 4) == 0);
                if (calm_requests > 0) begin
                    calm_requests--;
                end
                send_request(req, 1'b1);
            end
        end

        drain();
        if (tracker.faults == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
